/* design/qfsp_pkg.sv */
// package for the udp flow statistics parser
// types, constants and codes shared by the front, queue, back and top level
// no dependencies
package qfsp_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int ID_ENTRIES   = 1024;
  localparam int FLOW_AW      = $clog2(FLOW_ENTRIES);
  localparam int ID_AW        = $clog2(ID_ENTRIES);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  TYPE_MASK      = 8'hF0;
  localparam logic [7:0]  TYPE_HANDSHAKE = 8'hC0;
  localparam logic [7:0]  QUIC_HDR_BYTES = 8'd18;
  localparam logic [4:0]  PERIOD_RESET   = 5'd8;

  typedef enum logic [1:0] {
    OUT_FILTERED  = 2'd0,
    OUT_MALFORMED = 2'd1,
    OUT_COUNTED   = 2'd2,
    OUT_FULL      = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CLS_FILTERED  = 2'd0,
    CLS_MALFORMED = 2'd1,
    CLS_FULL_HDR  = 2'd2
  } class_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [63:0] flow_packets;
    logic [63:0] flow_malformed;
    logic [63:0] flow_handshakes;
    logic [63:0] id_packets;
    logic        id_valid;
    logic        summary_due;
  } out_item_t;

  typedef struct packed {
    class_t      cls;
    logic [31:0] source;
    logic [31:0] dest;
    logic        handshake;
    logic [63:0] conn_id;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSCAN,
    ST_FRD,
    ST_FUPD,
    ST_ISCAN,
    ST_IRD,
    ST_IUPD,
    ST_OUT
  } state_t;

endpackage

/* design/qfsp_front.sv */
// front part: takes frame bytes, captures the header fields and classifies
// each frame at its last byte into a job for the back part; uses qfsp_pkg
module qfsp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  qfsp_pkg::in_item_t in_item,
  output logic             in_stall,
  output logic             job_valid,
  output qfsp_pkg::job_t   job,
  input  logic             job_full
);

  logic [6:0]  byte_offset;
  logic [15:0] ethertype;
  logic [3:0]  header_words;
  logic [7:0]  protocol;
  logic [31:0] source;
  logic [31:0] dest;
  logic [7:0]  quic_type;
  logic [63:0] conn_id;

  logic [7:0]  b;
  logic [7:0]  off;
  logic [7:0]  quic_start;
  logic [7:0]  len;
  logic        take;
  logic [15:0] ethertype_next;
  logic [7:0]  protocol_next;
  logic [31:0] source_next;
  logic [31:0] dest_next;
  logic [7:0]  type_next;
  logic [63:0] conn_id_next;
  logic [3:0]  header_words_next;

  assign in_stall = job_full;
  assign take     = in_valid && !job_full;
  assign b        = in_item.frame_byte;
  assign off      = {1'b0, byte_offset};
  assign quic_start = 8'd22 + {2'b00, header_words, 2'b00};
  assign len      = off + 8'd1;

  always_comb begin
    ethertype_next    = ethertype;
    header_words_next = header_words;
    protocol_next     = protocol;
    source_next       = source;
    dest_next         = dest;
    type_next         = quic_type;
    conn_id_next      = conn_id;
    if (off == 8'd12) ethertype_next[15:8] = b;
    if (off == 8'd13) ethertype_next[7:0] = b;
    if (off == 8'd14) header_words_next = b[3:0];
    if (off == 8'd23) protocol_next = b;
    if (off >= 8'd26 && off <= 8'd29) source_next = {source[23:0], b};
    if (off >= 8'd30 && off <= 8'd33) dest_next = {dest[23:0], b};
    if (off > 8'd14) begin
      if (off == quic_start) type_next = b;
      if (off >= quic_start + 8'd1 && off <= quic_start + 8'd8) begin
        conn_id_next = {conn_id[55:0], b};
      end
    end
  end

  always_comb begin
    job.source    = source_next;
    job.dest      = dest_next;
    job.conn_id   = conn_id_next;
    job.handshake = (type_next & qfsp_pkg::TYPE_MASK) == qfsp_pkg::TYPE_HANDSHAKE;
    if (len < 8'd34 || ethertype_next != qfsp_pkg::ETHERTYPE_IPV4 ||
        protocol_next != qfsp_pkg::PROTO_UDP || len <= quic_start) begin
      job.cls = qfsp_pkg::CLS_FILTERED;
    end else if ({1'b0, len} < {1'b0, quic_start} + {1'b0, qfsp_pkg::QUIC_HDR_BYTES}) begin
      job.cls = qfsp_pkg::CLS_MALFORMED;
    end else begin
      job.cls = qfsp_pkg::CLS_FULL_HDR;
    end
  end

  assign job_valid = take && in_item.last_byte;

  always_ff @(posedge clk) begin
    if (rst || (take && in_item.last_byte)) begin
      byte_offset  <= '0;
      ethertype    <= '0;
      header_words <= '0;
      protocol     <= '0;
      source       <= '0;
      dest         <= '0;
      quic_type    <= '0;
      conn_id      <= '0;
    end else if (take) begin
      if (byte_offset != 7'd127) byte_offset <= byte_offset + 7'd1;
      ethertype    <= ethertype_next;
      header_words <= header_words_next;
      protocol     <= protocol_next;
      source       <= source_next;
      dest         <= dest_next;
      quic_type    <= type_next;
      conn_id      <= conn_id_next;
    end
  end

endmodule

/* design/qfsp_queue.sv */
// short job queue between front and back parts
// uses qfsp_pkg
module qfsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  qfsp_pkg::job_t wr_job,
  output logic           full,
  output logic           rd_valid,
  output qfsp_pkg::job_t rd_job,
  input  logic           rd_take
);

  qfsp_pkg::job_t slots [qfsp_pkg::QUEUE_DEPTH];
  logic [qfsp_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [qfsp_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [qfsp_pkg::QUEUE_AW:0]   count;
  logic do_wr;
  logic do_rd;

  assign full     = count == (qfsp_pkg::QUEUE_AW+1)'(qfsp_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (qfsp_pkg::QUEUE_AW+1)'(do_wr) - (qfsp_pkg::QUEUE_AW+1)'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> count == (qfsp_pkg::QUEUE_AW+1)'(qfsp_pkg::QUEUE_DEPTH))
    else $error("queue count mismatch");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != (qfsp_pkg::QUEUE_AW+1)'(qfsp_pkg::QUEUE_DEPTH)) |->
      (wr_ptr - rd_ptr) == count[qfsp_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");
  a_empty_no_read: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !wr_valid) |=> count == '0)
    else $error("queue count moved without transfer");

endmodule

/* design/qfsp_back.sv */
// back part: flow and connection id table lookups, counter updates, result
// register; scans the filled part of each table one entry per cycle; uses qfsp_pkg
module qfsp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               job_valid,
  input  qfsp_pkg::job_t     job,
  output logic               job_take,
  output logic               out_valid,
  output qfsp_pkg::out_item_t out_item,
  input  logic               out_stall
);

  localparam int FAW = qfsp_pkg::FLOW_AW;
  localparam int IAW = qfsp_pkg::ID_AW;

  logic [63:0] flow_keys [qfsp_pkg::FLOW_ENTRIES];
  logic [63:0] flow_pkts [qfsp_pkg::FLOW_ENTRIES];
  logic [63:0] flow_malf [qfsp_pkg::FLOW_ENTRIES];
  logic [63:0] flow_hs   [qfsp_pkg::FLOW_ENTRIES];
  logic [63:0] id_keys [qfsp_pkg::ID_ENTRIES];
  logic [63:0] id_cnts [qfsp_pkg::ID_ENTRIES];

  qfsp_pkg::state_t state, state_next;
  logic [4:0]  period;
  logic [FAW:0] flow_fill;
  logic [IAW:0] id_fill;
  logic [FAW:0] fidx;
  logic [IAW:0] iidx;
  logic [FAW-1:0] fsel;
  logic [IAW-1:0] isel;
  logic        fnew;
  logic        inew;
  logic        iok;
  logic        fhit;
  logic        ihit;
  logic [63:0] fkey_rd;
  logic [63:0] ikey_rd;
  logic [63:0] rd_pkts;
  logic [63:0] rd_malf;
  logic [63:0] rd_hs;
  logic [63:0] rd_id;
  logic [63:0] new_pkts;
  logic [63:0] new_malf;
  logic [63:0] new_hs;
  logic [63:0] new_id;
  logic [63:0] fkey;
  logic [63:0] mask;
  qfsp_pkg::out_item_t res;

  assign fkey = {job.source, job.dest};
  assign mask = (64'd1 << period) - 64'd1;
  // entries are filled in order and never freed, so index below fill is in use
  assign fhit = fidx != '0 && fkey_rd == fkey;
  assign ihit = iidx != '0 && ikey_rd == job.conn_id;

  always_ff @(posedge clk) begin
    fkey_rd <= flow_keys[fidx[FAW-1:0]];
    ikey_rd <= id_keys[iidx[IAW-1:0]];
    rd_pkts <= flow_pkts[fsel];
    rd_malf <= flow_malf[fsel];
    rd_hs   <= flow_hs[fsel];
    rd_id   <= id_cnts[isel];
  end

  always_comb begin
    new_pkts = fnew ? 64'd0 : rd_pkts;
    new_malf = fnew ? 64'd0 : rd_malf;
    new_hs   = fnew ? 64'd0 : rd_hs;
    new_id   = (inew ? 64'd0 : rd_id) + 64'd1;
    if (job.cls == qfsp_pkg::CLS_MALFORMED) begin
      new_malf = new_malf + 64'd1;
    end else begin
      new_pkts = new_pkts + 64'd1;
      if (job.handshake) new_hs = new_hs + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qfsp_pkg::ST_FUPD) begin
      if (fnew) flow_keys[fsel] <= fkey;
      flow_pkts[fsel] <= new_pkts;
      flow_malf[fsel] <= new_malf;
      flow_hs[fsel]   <= new_hs;
    end
    if (state == qfsp_pkg::ST_IUPD && iok) begin
      if (inew) id_keys[isel] <= job.conn_id;
      id_cnts[isel] <= new_id;
    end
  end

  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    unique case (state)
      qfsp_pkg::ST_IDLE: begin
        if (job_valid) begin
          if (job.cls == qfsp_pkg::CLS_FILTERED) state_next = qfsp_pkg::ST_OUT;
          else state_next = qfsp_pkg::ST_FSCAN;
        end
      end
      qfsp_pkg::ST_FSCAN: begin
        if (fhit) begin
          state_next = qfsp_pkg::ST_FRD;
        end else if (fidx == flow_fill) begin
          if (flow_fill == (FAW+1)'(qfsp_pkg::FLOW_ENTRIES)) state_next = qfsp_pkg::ST_OUT;
          else state_next = qfsp_pkg::ST_FRD;
        end
      end
      qfsp_pkg::ST_FRD: state_next = qfsp_pkg::ST_FUPD;
      qfsp_pkg::ST_FUPD: begin
        if (job.cls == qfsp_pkg::CLS_MALFORMED) state_next = qfsp_pkg::ST_OUT;
        else state_next = qfsp_pkg::ST_ISCAN;
      end
      qfsp_pkg::ST_ISCAN: begin
        if (ihit || iidx == id_fill) state_next = qfsp_pkg::ST_IRD;
      end
      qfsp_pkg::ST_IRD: state_next = qfsp_pkg::ST_IUPD;
      qfsp_pkg::ST_IUPD: state_next = qfsp_pkg::ST_OUT;
      qfsp_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          job_take   = 1'b1;
          state_next = qfsp_pkg::ST_IDLE;
        end
      end
      default: state_next = qfsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qfsp_pkg::ST_IDLE;
      period    <= qfsp_pkg::PERIOD_RESET;
      flow_fill <= '0;
      id_fill   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) period <= cfg_data;
      if (state == qfsp_pkg::ST_FUPD && fnew) flow_fill <= flow_fill + 1'b1;
      if (state == qfsp_pkg::ST_IUPD && iok && inew) id_fill <= id_fill + 1'b1;
      out_valid <= job_take || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      qfsp_pkg::ST_IDLE: begin
        fidx <= '0;
        iidx <= '0;
        fnew <= 1'b0;
        inew <= 1'b0;
        iok  <= 1'b0;
        if (job_valid && job.cls != qfsp_pkg::CLS_FILTERED) begin
          res <= '{outcome: qfsp_pkg::OUT_FULL, source_address: job.source,
                   dest_address: job.dest, default: '0};
        end else begin
          res <= '0;
        end
      end
      qfsp_pkg::ST_FSCAN: begin
        fidx <= fidx + 1'b1;
        if (fhit) begin
          fsel <= fidx[FAW-1:0] - 1'b1;
          fnew <= 1'b0;
        end else if (fidx == flow_fill) begin
          fsel <= flow_fill[FAW-1:0];
          fnew <= 1'b1;
        end
      end
      qfsp_pkg::ST_FUPD: begin
        res.flow_packets    <= new_pkts;
        res.flow_malformed  <= new_malf;
        res.flow_handshakes <= new_hs;
        res.summary_due     <= (new_pkts & mask) == 64'd0 &&
                               job.cls != qfsp_pkg::CLS_MALFORMED;
        res.outcome <= job.cls == qfsp_pkg::CLS_MALFORMED ?
                       qfsp_pkg::OUT_MALFORMED : qfsp_pkg::OUT_COUNTED;
      end
      qfsp_pkg::ST_ISCAN: begin
        iidx <= iidx + 1'b1;
        if (ihit) begin
          isel <= iidx[IAW-1:0] - 1'b1;
          inew <= 1'b0;
          iok  <= 1'b1;
        end else if (iidx == id_fill && id_fill != (IAW+1)'(qfsp_pkg::ID_ENTRIES)) begin
          isel <= id_fill[IAW-1:0];
          inew <= 1'b1;
          iok  <= 1'b1;
        end
      end
      qfsp_pkg::ST_IUPD: begin
        if (iok) begin
          res.id_packets <= new_id;
          res.id_valid   <= 1'b1;
        end
      end
      default: ;
    endcase
    if (job_take) out_item <= res;
  end

  a_take_in_out: assert property (@(posedge clk) disable iff (rst)
    job_take |-> state == qfsp_pkg::ST_OUT && job_valid)
    else $error("job taken outside result state");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    job_take |=> out_valid)
    else $error("result not presented after job");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

/* design/quic_flow_stats_parser_top.sv */
// udp flow statistics parser, top level
// channels: in (frame_byte, last_byte) with in_valid/in_stall, out result
//   item with out_valid/out_stall, one config register summary_period_log2
// the front takes one byte a cycle and captures header fields; on the last
//   byte it queues a job (four deep) and stalls only while the queue is full
// the back works one job at a time: a filtered frame goes straight to its
//   result; other frames scan the filled flow entries one a cycle; a
//   malformed frame gives its result after the flow update, a full flow
//   table after the scan; a full header also scans the filled id entries
//   and gives its result after the id update
// the back pops each job in the same cycle as it loads its result and looks
//   at the next job the cycle after; frames are absorbed by the queue only
//   while the back keeps up; otherwise in_stall rises
// the result sits in an output register; while out_stall is high it holds
//   and the back waits, the queue filling behind it
// reset (synchronous, rst high) empties the queue and result register,
//   empties both tables and sets the period register to 8
// uses qfsp_pkg, qfsp_front, qfsp_queue, qfsp_back
module quic_flow_stats_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  qfsp_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output qfsp_pkg::out_item_t out_item,
  input  logic                out_stall,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data
);

  logic           fj_valid;
  qfsp_pkg::job_t fj;
  logic           q_full;
  logic           q_valid;
  qfsp_pkg::job_t q_job;
  logic           q_take;

  qfsp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_item(in_item),
    .in_stall(in_stall), .job_valid(fj_valid), .job(fj), .job_full(q_full)
  );

  qfsp_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fj_valid), .wr_job(fj), .full(q_full),
    .rd_valid(q_valid), .rd_job(q_job), .rd_take(q_take)
  );

  qfsp_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .job_valid(q_valid), .job(q_job), .job_take(q_take),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
  );

endmodule

/* dv/quic_flow_stats_parser_top_test.sv */
// testbench for quic_flow_stats_parser_top: drives ethernet frames byte by byte
// and checks every result transfer against a built-in flow and id table predictor
// depends on qfsp_pkg and quic_flow_stats_parser_top
`timescale 1ns / 1ps

module quic_flow_stats_parser_top_test;

  typedef struct {
    int          len;
    logic [15:0] eth;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  qtype;
    logic [63:0] cid;
    bit          typed;
  } frame_spec_t;

  logic                clk = 0;
  logic                rst = 1;
  logic                in_valid = 0;
  qfsp_pkg::in_item_t  in_item = '0;
  logic                in_stall;
  logic                out_valid;
  qfsp_pkg::out_item_t out_item;
  logic                out_stall = 0;
  logic                cfg_we = 0;
  logic [4:0]          cfg_data = '0;

  quic_flow_stats_parser_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  int          pos = 0;
  logic [15:0] cap_eth = '0;
  logic [3:0]  cap_words = '0;
  logic [7:0]  cap_proto = '0;
  logic [31:0] cap_src = '0;
  logic [31:0] cap_dst = '0;
  logic [7:0]  cap_type = '0;
  logic [63:0] cap_cid = '0;
  logic [4:0]  period_log2 = qfsp_pkg::PERIOD_RESET;
  logic [63:0] flow_pkts [logic [63:0]];
  logic [63:0] flow_bad [logic [63:0]];
  logic [63:0] flow_hs [logic [63:0]];
  logic [63:0] id_pkts [logic [63:0]];

  qfsp_pkg::out_item_t expected_q [$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          use_typed = 0;
  int          stall_left = 0;
  bit          stall_mode = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic clear_capture();
    pos = 0; cap_eth = '0; cap_words = '0; cap_proto = '0;
    cap_src = '0; cap_dst = '0; cap_type = '0; cap_cid = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic lastb,
                              output bit has, output qfsp_pkg::out_item_t r);
    int qs;
    int len;
    logic [63:0] key;
    logic [63:0] mask;
    r = '0;
    has = 0;
    if (pos == 12) cap_eth[15:8] = b;
    if (pos == 13) cap_eth[7:0] = b;
    if (pos == 14) cap_words = b[3:0];
    if (pos == 23) cap_proto = b;
    if (pos >= 26 && pos <= 29) cap_src = {cap_src[23:0], b};
    if (pos >= 30 && pos <= 33) cap_dst = {cap_dst[23:0], b};
    qs = 22 + 4 * int'(cap_words);
    if (pos > 14) begin
      if (pos == qs) cap_type = b;
      if (pos >= qs + 1 && pos <= qs + 8) cap_cid = {cap_cid[55:0], b};
    end
    if (!lastb) begin
      if (pos < 127) pos++;
      return;
    end
    has = 1;
    len = pos + 1;
    if (len < 34 || cap_eth != qfsp_pkg::ETHERTYPE_IPV4 || cap_proto != qfsp_pkg::PROTO_UDP ||
        len <= qs) begin
      clear_capture();
      return;
    end
    r.source_address = cap_src;
    r.dest_address = cap_dst;
    key = {cap_src, cap_dst};
    if (!flow_pkts.exists(key)) begin
      if (flow_pkts.num() >= qfsp_pkg::FLOW_ENTRIES) begin
        r.outcome = qfsp_pkg::OUT_FULL;
        clear_capture();
        return;
      end
      flow_pkts[key] = '0; flow_bad[key] = '0; flow_hs[key] = '0;
    end
    if (len < qs + int'(qfsp_pkg::QUIC_HDR_BYTES)) begin
      flow_bad[key]++;
      r.outcome = qfsp_pkg::OUT_MALFORMED;
    end else begin
      flow_pkts[key]++;
      if ((cap_type & qfsp_pkg::TYPE_MASK) == qfsp_pkg::TYPE_HANDSHAKE) flow_hs[key]++;
      if (!id_pkts.exists(cap_cid) && id_pkts.num() < qfsp_pkg::ID_ENTRIES)
        id_pkts[cap_cid] = '0;
      if (id_pkts.exists(cap_cid)) begin
        id_pkts[cap_cid]++;
        r.id_packets = id_pkts[cap_cid];
        r.id_valid = 1'b1;
      end
      mask = (64'd1 << period_log2) - 64'd1;
      r.summary_due = (flow_pkts[key] & mask) == '0;
      r.outcome = qfsp_pkg::OUT_COUNTED;
    end
    r.flow_packets = flow_pkts[key];
    r.flow_malformed = flow_bad[key];
    r.flow_handshakes = flow_hs[key];
    clear_capture();
  endtask

  always @(posedge clk) begin
    bit has;
    qfsp_pkg::out_item_t r;
    qfsp_pkg::out_item_t e;
    if (!rst) begin
      if (cfg_we) period_log2 = cfg_data;
      if (in_valid && !in_stall) begin
        predict_byte(in_item.frame_byte, in_item.last_byte, has, r);
        if (has) expected_q.push_back(use_typed ? qfsp_pkg::out_item_t'('0) : r);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_item.flow_packets, '0);
        end else begin
          e = expected_q.pop_front();
          if (out_item.outcome !== e.outcome)
            report("outcome", 64'(out_item.outcome), 64'(e.outcome));
          if (out_item.source_address !== e.source_address)
            report("source_address", 64'(out_item.source_address), 64'(e.source_address));
          if (out_item.dest_address !== e.dest_address)
            report("dest_address", 64'(out_item.dest_address), 64'(e.dest_address));
          if (out_item.flow_packets !== e.flow_packets)
            report("flow_packets", out_item.flow_packets, e.flow_packets);
          if (out_item.flow_malformed !== e.flow_malformed)
            report("flow_malformed", out_item.flow_malformed, e.flow_malformed);
          if (out_item.flow_handshakes !== e.flow_handshakes)
            report("flow_handshakes", out_item.flow_handshakes, e.flow_handshakes);
          if (out_item.id_packets !== e.id_packets)
            report("id_packets", out_item.id_packets, e.id_packets);
          if (out_item.id_valid !== e.id_valid)
            report("id_valid", 64'(out_item.id_valid), 64'(e.id_valid));
          if (out_item.summary_due !== e.summary_due)
            report("summary_due", 64'(out_item.summary_due), 64'(e.summary_due));
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 9) < 3);
      stall_left = stall_mode ? $urandom_range(1, 6) : $urandom_range(1, 40);
    end
    stall_left--;
    out_stall <= stall_mode;
  end

  task automatic send_byte(input logic [7:0] b, input logic lastb, input bit typed);
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 80);
      n = $urandom_range(0, 4);
      repeat (n) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    use_typed = typed;
    in_valid <= 1'b1;
    in_item <= '{frame_byte: b, last_byte: lastb};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_spec_t s);
    logic [7:0] raw [160];
    int qs;
    foreach (raw[i]) raw[i] = 8'($urandom);
    raw[12] = s.eth[15:8];
    raw[13] = s.eth[7:0];
    raw[14] = s.vihl;
    raw[23] = s.proto;
    for (int k = 0; k < 4; k++) begin
      raw[26 + k] = s.src[31 - 8 * k -: 8];
      raw[30 + k] = s.dst[31 - 8 * k -: 8];
    end
    qs = 22 + 4 * int'(s.vihl[3:0]);
    raw[qs] = s.qtype;
    for (int k = 0; k < 8; k++) raw[qs + 1 + k] = s.cid[63 - 8 * k -: 8];
    for (int i = 0; i < s.len; i++) send_byte(raw[i], i == s.len - 1, s.typed);
  endtask

  task automatic write_period(input logic [4:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic frame_spec_t good_spec(input int len, input logic [31:0] src,
                                            input logic [31:0] dst, input logic [63:0] cid);
    frame_spec_t s;
    s.len = len; s.eth = qfsp_pkg::ETHERTYPE_IPV4; s.vihl = 8'h45;
    s.proto = qfsp_pkg::PROTO_UDP;
    s.src = src; s.dst = dst; s.qtype = 8'($urandom); s.cid = cid; s.typed = 0;
    return s;
  endfunction

  function automatic frame_spec_t random_spec();
    frame_spec_t s;
    int qs;
    int pick;
    s = good_spec(0, 32'h0A00_0001 + 32'($urandom_range(0, 4)),
                  32'h0A00_0101 + 32'($urandom_range(0, 2)),
                  {$urandom_range(0, 5) == 0 ? 32'($urandom) : 32'h1234_5678,
                   32'($urandom_range(0, 7))});
    if ($urandom_range(0, 9) < 4) s.qtype = {4'hC, 4'($urandom)};
    s.vihl = {4'($urandom), $urandom_range(0, 7) == 0 ? 4'($urandom) : 4'd5};
    qs = 22 + 4 * int'(s.vihl[3:0]);
    pick = $urandom_range(0, 19);
    if (pick < 13) s.len = qs + 18 + $urandom_range(0, 20);
    else if (pick < 15) s.len = $urandom_range(qs - 1, qs + 17);
    else if (pick == 15) s.len = $urandom_range(100, 140);
    else if (pick == 16) s.eth = 16'($urandom);
    else if (pick == 17) s.proto = 8'($urandom);
    else s.len = $urandom_range(1, 40);
    if (s.len == 0) s.len = qs + 18;
    if (s.len < 1) s.len = 1;
    return s;
  endfunction

  frame_spec_t directed [$];

  initial begin
    frame_spec_t s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // filtered cases carry typed expectations of all zero
    s = good_spec(10, 32'h0A00_0001, 32'h0A00_0101, 64'd1); s.typed = 1; directed.push_back(s);
    s.len = 13; directed.push_back(s);
    s.len = 60; s.eth = 16'h86DD; directed.push_back(s);
    s.eth = qfsp_pkg::ETHERTYPE_IPV4; s.len = 33; directed.push_back(s);
    s.len = 60; s.proto = 8'd6; directed.push_back(s);
    s.proto = qfsp_pkg::PROTO_UDP; s.len = 42; directed.push_back(s);
    s = good_spec(43, 32'h0A00_0001, 32'h0A00_0101, 64'd1); directed.push_back(s);
    s.len = 59; directed.push_back(s);
    s.len = 60; s.qtype = qfsp_pkg::TYPE_HANDSHAKE; directed.push_back(s);
    s.qtype = 8'hCF; s.cid = '1; directed.push_back(s);
    s.qtype = 8'hBF; s.len = 128; directed.push_back(s);
    s.len = 140; directed.push_back(s);
    s.vihl = 8'h4F; s.len = 100; directed.push_back(s);
    s.vihl = 8'h40; s.len = 40; directed.push_back(s);
    s.vihl = 8'h44; s.len = 60; directed.push_back(s);
    s = good_spec(60, '1, '1, '0); s.qtype = 8'hFF; directed.push_back(s);
    s = good_spec(61, '0, '0, 64'd1); s.qtype = 8'h00; s.vihl = 8'hF5; directed.push_back(s);
    s = good_spec(60, '1, '1, '0); directed.push_back(s);
    foreach (directed[i]) send_frame(directed[i]);

    write_period(5'd1);
    while (bytes_sent < 1400) send_frame(random_spec());
    write_period(5'd0);
    while (bytes_sent < 1650) send_frame(random_spec());
    write_period(5'd16);
    while (bytes_sent < 1900) send_frame(random_spec());

    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("quic_flow_stats_parser_top_test passed");
    end else begin
      $display("quic_flow_stats_parser_top_test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("quic_flow_stats_parser_top_test failed");
    $finish;
  end

endmodule

/* sim.f */
design/qfsp_pkg.sv
design/qfsp_front.sv
design/qfsp_queue.sv
design/qfsp_back.sv
design/quic_flow_stats_parser_top.sv
dv/quic_flow_stats_parser_top_test.sv
